>>> rtl/sdrd_pkg.sv
// Package for the SD SPI sector read engine: phase and status codes,
// protocol byte constants, and the state, config and result structs.
// No dependencies.
package sdrd_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_SHIFT = 9;

  localparam logic [7:0] CMD17_BYTE  = 8'h51;
  localparam logic [7:0] DUMMY_CRC   = 8'h01;
  localparam logic [7:0] DATA_TOKEN  = 8'hFE;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [15:0] POLL_LIMIT_RESET = 16'd8192;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_XFER  = 1'b1;

  localparam logic [1:0] REG_BLOCK_ADDR  = 2'd0;
  localparam logic [1:0] REG_RESP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_TOKEN_LIMIT = 2'd2;

  localparam logic [2:0] FRAME_ADDR3 = 3'd1;
  localparam logic [2:0] FRAME_ADDR2 = 3'd2;
  localparam logic [2:0] FRAME_ADDR1 = 3'd3;
  localparam logic [2:0] FRAME_ADDR0 = 3'd4;
  localparam logic [2:0] FRAME_END   = 3'd6;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_FRAME = 4'd1,
    PH_RESP  = 4'd2,
    PH_TOKEN = 4'd3,
    PH_DATA  = 4'd4,
    PH_CRC   = 4'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ARG    = 3'd1,
    ST_REJECT = 3'd2,
    ST_TOKEN  = 3'd3,
    ST_LINK   = 3'd4
  } status_t;

  typedef struct packed {
    logic        block_addressing;
    logic [15:0] response_poll_limit;
    logic [15:0] token_poll_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        link_good;
    logic [31:0] card_address;
    logic [23:0] sectors_left;
    logic [9:0]  bytes_left_in_sector;
    logic [8:0]  offset_left;
    logic [31:0] length_left;
    logic [15:0] poll_count;
    logic [2:0]  frame_index;
  } state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_restart;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    status_t    status;
  } result_t;

endpackage

>>> rtl/sd_spi_sector_read_engine_top.sv
// Top level of the SD SPI sector read engine: input register, config
// registers, state register and result register around sdrd_step.
// Depends on sdrd_pkg and sdrd_step.
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | cmd, start_sector, start_offset, read_length, rx_byte
//  out     | out_valid / out_ready | tx_valid, tx_byte, select_restart, data_valid,
//          |                       | data_byte, done_res, status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle unless the output stalls: input register, combinational step,
// result register. A word's result is registered once the result register is free.
// The input stage holds while the result register is full and not taken.
// Ignored words (start while busy, exchange while idle) give no result.
// rst is synchronous; cfg_ready is always high.
module sd_spi_sector_read_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] start_sector,
  input  logic [15:0] start_offset,
  input  logic [31:0] read_length,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        select_restart,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic        done_res,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sdrd_pkg::cfg_t    cfg;
  sdrd_pkg::state_t  state;
  sdrd_pkg::state_t  state_next;
  sdrd_pkg::result_t res_next;
  sdrd_pkg::result_t res;
  logic              has_res;

  logic        stage_valid;
  logic        stage_cmd;
  logic [31:0] stage_sector;
  logic [15:0] stage_offset;
  logic [31:0] stage_length;
  logic [7:0]  stage_rx;
  logic        step_go;

  assign cfg_ready = 1'b1;
  assign step_go   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_addressing    <= 1'b0;
      cfg.response_poll_limit <= sdrd_pkg::POLL_LIMIT_RESET;
      cfg.token_poll_limit    <= sdrd_pkg::POLL_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdrd_pkg::REG_BLOCK_ADDR:  cfg.block_addressing    <= cfg_data[0];
        sdrd_pkg::REG_RESP_LIMIT:  cfg.response_poll_limit <= cfg_data[15:0];
        sdrd_pkg::REG_TOKEN_LIMIT: cfg.token_poll_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (step_go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd    <= cmd;
      stage_sector <= start_sector;
      stage_offset <= start_offset;
      stage_length <= read_length;
      stage_rx     <= rx_byte;
    end
  end

  sdrd_step u_step (
    .cfg          (cfg),
    .cur          (state),
    .cmd          (stage_cmd),
    .start_sector (stage_sector),
    .start_offset (stage_offset),
    .read_length  (stage_length),
    .rx_byte      (stage_rx),
    .nxt          (state_next),
    .res          (res_next),
    .has_res      (has_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase                <= sdrd_pkg::PH_IDLE;
      state.link_good            <= 1'b1;
      state.card_address         <= 32'd0;
      state.sectors_left         <= 24'd0;
      state.bytes_left_in_sector <= 10'd0;
      state.offset_left          <= 9'd0;
      state.length_left          <= 32'd0;
      state.poll_count           <= 16'd0;
      state.frame_index          <= 3'd0;
    end else if (step_go) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= has_res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && has_res) begin
      res <= res_next;
    end
  end

  assign tx_valid       = res.tx_valid;
  assign tx_byte        = res.tx_byte;
  assign select_restart = res.select_restart;
  assign data_valid     = res.data_valid;
  assign data_byte      = res.data_byte;
  assign done_res       = res.done_res;
  assign status         = res.status;

`ifndef SYNTHESIS
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !tx_valid && !data_valid)
    else $error("done word drives an exchange or data");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == sdrd_pkg::ST_OK)
    else $error("nonzero status without done");

  a_restart_cmd17: assert property (@(posedge clk) disable iff (rst)
    out_valid && select_restart |-> tx_valid && tx_byte == sdrd_pkg::CMD17_BYTE)
    else $error("select restart not on a command frame start");

  a_link_sticky: assert property (@(posedge clk) disable iff (rst)
    !state.link_good |=> !state.link_good)
    else $error("link marked good again without reset");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(state))
    else $error("state moved while result stalled");
`endif

endmodule

>>> rtl/sdrd_step.sv
// Combinational step of the read engine: one word in, next state and at
// most one result word out.
// Depends on sdrd_pkg.
module sdrd_step (
  input  sdrd_pkg::cfg_t    cfg,
  input  sdrd_pkg::state_t  cur,
  input  logic              cmd,
  input  logic [31:0]       start_sector,
  input  logic [15:0]       start_offset,
  input  logic [31:0]       read_length,
  input  logic [7:0]        rx_byte,
  output sdrd_pkg::state_t  nxt,
  output sdrd_pkg::result_t res,
  output logic              has_res
);

  logic [32:0] end_sum;
  logic [31:0] last_byte;
  logic        arg_bad;
  logic [15:0] poll_inc;
  logic [9:0]  bytes_dec;
  logic [7:0]  frame_byte;

  assign end_sum   = {1'b0, read_length} + {17'd0, start_offset};
  assign last_byte = end_sum[31:0] - 32'd1;
  assign arg_bad   = (start_offset >= 16'(sdrd_pkg::SECTOR_BYTES)) || end_sum[32] ||
                     (!cfg.block_addressing && (start_sector[31:23] != 9'd0));
  assign poll_inc  = cur.poll_count + 16'd1;
  assign bytes_dec = (cur.bytes_left_in_sector != 10'd0) ?
                     cur.bytes_left_in_sector - 10'd1 : 10'd0;

  always_comb begin
    case (cur.frame_index)
      sdrd_pkg::FRAME_ADDR3: frame_byte = cur.card_address[31:24];
      sdrd_pkg::FRAME_ADDR2: frame_byte = cur.card_address[23:16];
      sdrd_pkg::FRAME_ADDR1: frame_byte = cur.card_address[15:8];
      sdrd_pkg::FRAME_ADDR0: frame_byte = cur.card_address[7:0];
      default:               frame_byte = sdrd_pkg::DUMMY_CRC;
    endcase
  end

  always_comb begin
    nxt     = cur;
    res     = '0;
    has_res = 1'b0;
    if (cmd == sdrd_pkg::CMD_START) begin
      if (cur.phase == sdrd_pkg::PH_IDLE) begin
        has_res = 1'b1;
        if (!cur.link_good) begin
          res.done_res = 1'b1;
          res.status   = sdrd_pkg::ST_LINK;
        end else if (read_length == 32'd0) begin
          res.done_res = 1'b1;
          res.status   = sdrd_pkg::ST_OK;
        end else if (arg_bad) begin
          res.done_res = 1'b1;
          res.status   = sdrd_pkg::ST_ARG;
        end else begin
          nxt.card_address = cfg.block_addressing ? start_sector :
                             {start_sector[22:0], 9'd0};
          nxt.sectors_left = {1'b0, last_byte[31:sdrd_pkg::SECTOR_SHIFT]};
          nxt.offset_left  = start_offset[8:0];
          nxt.length_left  = read_length;
          nxt.bytes_left_in_sector = 10'd0;
          nxt.poll_count   = 16'd0;
          nxt.phase        = sdrd_pkg::PH_FRAME;
          nxt.frame_index  = sdrd_pkg::FRAME_ADDR3;
          res.tx_valid       = 1'b1;
          res.tx_byte        = sdrd_pkg::CMD17_BYTE;
          res.select_restart = 1'b1;
        end
      end
    end else begin
      case (cur.phase)
        sdrd_pkg::PH_IDLE: begin
          has_res = 1'b0;
        end
        sdrd_pkg::PH_FRAME: begin
          has_res      = 1'b1;
          res.tx_valid = 1'b1;
          if (cur.frame_index < sdrd_pkg::FRAME_END) begin
            res.tx_byte     = frame_byte;
            nxt.frame_index = cur.frame_index + 3'd1;
          end else begin
            res.tx_byte    = sdrd_pkg::IDLE_BYTE;
            nxt.phase      = sdrd_pkg::PH_RESP;
            nxt.poll_count = 16'd0;
          end
        end
        sdrd_pkg::PH_RESP: begin
          has_res        = 1'b1;
          nxt.poll_count = poll_inc;
          if (!rx_byte[7]) begin
            if (rx_byte != 8'd0) begin
              res.done_res  = 1'b1;
              res.status    = sdrd_pkg::ST_REJECT;
              nxt.phase     = sdrd_pkg::PH_IDLE;
              nxt.link_good = 1'b0;
            end else begin
              res.tx_valid   = 1'b1;
              res.tx_byte    = sdrd_pkg::IDLE_BYTE;
              nxt.phase      = sdrd_pkg::PH_TOKEN;
              nxt.poll_count = 16'd0;
            end
          end else if (poll_inc >= cfg.response_poll_limit) begin
            res.done_res  = 1'b1;
            res.status    = sdrd_pkg::ST_REJECT;
            nxt.phase     = sdrd_pkg::PH_IDLE;
            nxt.link_good = 1'b0;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = sdrd_pkg::IDLE_BYTE;
          end
        end
        sdrd_pkg::PH_TOKEN: begin
          has_res        = 1'b1;
          nxt.poll_count = poll_inc;
          if (rx_byte != sdrd_pkg::IDLE_BYTE) begin
            if (rx_byte != sdrd_pkg::DATA_TOKEN) begin
              res.done_res  = 1'b1;
              res.status    = sdrd_pkg::ST_TOKEN;
              nxt.phase     = sdrd_pkg::PH_IDLE;
              nxt.link_good = 1'b0;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = sdrd_pkg::IDLE_BYTE;
              nxt.phase    = sdrd_pkg::PH_DATA;
              nxt.bytes_left_in_sector = 10'(sdrd_pkg::SECTOR_BYTES);
            end
          end else if (poll_inc >= cfg.token_poll_limit) begin
            res.done_res  = 1'b1;
            res.status    = sdrd_pkg::ST_TOKEN;
            nxt.phase     = sdrd_pkg::PH_IDLE;
            nxt.link_good = 1'b0;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = sdrd_pkg::IDLE_BYTE;
          end
        end
        sdrd_pkg::PH_DATA: begin
          has_res      = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = sdrd_pkg::IDLE_BYTE;
          if (cur.offset_left != 9'd0) begin
            nxt.offset_left = cur.offset_left - 9'd1;
          end else if (cur.length_left != 32'd0) begin
            nxt.length_left = cur.length_left - 32'd1;
            res.data_valid  = 1'b1;
            res.data_byte   = rx_byte;
          end
          nxt.bytes_left_in_sector = bytes_dec;
          if (bytes_dec == 10'd0) begin
            nxt.phase       = sdrd_pkg::PH_CRC;
            nxt.frame_index = 3'd0;
          end
        end
        sdrd_pkg::PH_CRC: begin
          has_res = 1'b1;
          if (cur.frame_index == 3'd0) begin
            nxt.frame_index = 3'd1;
            res.tx_valid    = 1'b1;
            res.tx_byte     = sdrd_pkg::IDLE_BYTE;
          end else if (cur.sectors_left != 24'd0) begin
            nxt.sectors_left = cur.sectors_left - 24'd1;
            nxt.card_address = cur.card_address + (cfg.block_addressing ?
                               32'd1 : 32'(sdrd_pkg::SECTOR_BYTES));
            nxt.phase          = sdrd_pkg::PH_FRAME;
            nxt.frame_index    = sdrd_pkg::FRAME_ADDR3;
            res.tx_valid       = 1'b1;
            res.tx_byte        = sdrd_pkg::CMD17_BYTE;
            res.select_restart = 1'b1;
          end else begin
            res.done_res = 1'b1;
            res.status   = sdrd_pkg::ST_OK;
            nxt.phase    = sdrd_pkg::PH_IDLE;
          end
        end
        default: begin
          nxt.phase = sdrd_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/sd_spi_sector_read_engine_top_test.sv
// Self-checking testbench for sd_spi_sector_read_engine_top: drives start and
// SPI exchange words, predicts each result word and compares field by field.
// Depends on sdrd_pkg and the engine RTL.
module sd_spi_sector_read_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] LAST_BYTE_SECTOR = 32'hFFFF_FFFF / sdrd_pkg::SECTOR_BYTES;
  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] sector;
    logic [15:0] offset;
    logic [31:0] length;
    logic [7:0]  rx;
  } word_t;

  typedef struct packed {
    sdrd_pkg::phase_t phase;
    logic             link_good;
    logic [31:0]      card_address;
    logic [23:0]      sectors_left;
    logic [9:0]       bytes_left_in_sector;
    logic [8:0]       offset_left;
    logic [31:0]      length_left;
    logic [15:0]      poll_count;
    logic [2:0]       frame_index;
  } read_ctx_t;

  typedef enum int {
    FAULT_NONE, FAULT_R1, FAULT_R1_SILENT, FAULT_TOKEN, FAULT_TOKEN_SILENT
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [31:0] start_sector = '0;
  logic [15:0] start_offset = '0;
  logic [31:0] read_length = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        select_restart;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        done_res;
  logic [2:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sd_spi_sector_read_engine_top u_dut (.*);

  word_t             pending[$];
  sdrd_pkg::result_t replies[$];
  read_ctx_t         eng;
  read_ctx_t         plan;
  sdrd_pkg::cfg_t    cfg_now;
  bit                took;
  bit                choke;
  bit                choke_req;
  int                send_gap;
  int                recv_gap;
  int                made;
  int                errors;
  int                cycles;
  int                words_in;
  int                results_seen;
  int                frames_seen;
  int                bytes_seen;
  int                ends[5];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one step of the read engine; returns 1 when the word yields a result
  function automatic bit step_engine(inout read_ctx_t s, input sdrd_pkg::cfg_t c,
                                     input word_t w, output sdrd_pkg::result_t r);
    bit                frame_go;
    bit                fin;
    bit                bad;
    sdrd_pkg::status_t st;
    logic [31:0]       sum;
    frame_go = 1'b0;
    fin = 1'b0;
    bad = 1'b0;
    st = sdrd_pkg::ST_OK;
    r = '0;
    r.status = sdrd_pkg::ST_OK;
    if (w.cmd == sdrd_pkg::CMD_START) begin
      if (s.phase != sdrd_pkg::PH_IDLE) return 1'b0;
      if (!s.link_good) begin
        fin = 1'b1;
        st = sdrd_pkg::ST_LINK;
      end else if (w.length == '0) begin
        fin = 1'b1;
      end else if (w.offset >= sdrd_pkg::SECTOR_BYTES ||
                   32'hFFFF_FFFF - w.offset < w.length ||
                   (!c.block_addressing && w.sector > LAST_BYTE_SECTOR)) begin
        fin = 1'b1;
        st = sdrd_pkg::ST_ARG;
      end else begin
        s.card_address = c.block_addressing ? w.sector :
                         w.sector << sdrd_pkg::SECTOR_SHIFT;
        sum = w.length + w.offset - 32'd1;
        s.sectors_left = 24'(sum >> sdrd_pkg::SECTOR_SHIFT);
        s.offset_left = w.offset[8:0];
        s.length_left = w.length;
        s.bytes_left_in_sector = '0;
        s.poll_count = '0;
        frame_go = 1'b1;
      end
    end else begin
      r.tx_valid = 1'b1;
      r.tx_byte = sdrd_pkg::IDLE_BYTE;
      case (s.phase)
        sdrd_pkg::PH_IDLE: return 1'b0;
        sdrd_pkg::PH_FRAME: begin
          if (s.frame_index < sdrd_pkg::FRAME_END) begin
            case (s.frame_index)
              sdrd_pkg::FRAME_ADDR3: r.tx_byte = s.card_address[31:24];
              sdrd_pkg::FRAME_ADDR2: r.tx_byte = s.card_address[23:16];
              sdrd_pkg::FRAME_ADDR1: r.tx_byte = s.card_address[15:8];
              sdrd_pkg::FRAME_ADDR0: r.tx_byte = s.card_address[7:0];
              default: r.tx_byte = sdrd_pkg::DUMMY_CRC;
            endcase
            s.frame_index = s.frame_index + 3'd1;
          end else begin
            s.phase = sdrd_pkg::PH_RESP;
            s.poll_count = '0;
          end
        end
        sdrd_pkg::PH_RESP: begin
          s.poll_count = s.poll_count + 16'd1;
          if (!w.rx[7]) begin
            if (w.rx != R1_READY) begin
              fin = 1'b1;
              bad = 1'b1;
              st = sdrd_pkg::ST_REJECT;
            end else begin
              s.phase = sdrd_pkg::PH_TOKEN;
              s.poll_count = '0;
            end
          end else if (s.poll_count >= c.response_poll_limit) begin
            fin = 1'b1;
            bad = 1'b1;
            st = sdrd_pkg::ST_REJECT;
          end
        end
        sdrd_pkg::PH_TOKEN: begin
          s.poll_count = s.poll_count + 16'd1;
          if (w.rx != sdrd_pkg::IDLE_BYTE) begin
            if (w.rx != sdrd_pkg::DATA_TOKEN) begin
              fin = 1'b1;
              bad = 1'b1;
              st = sdrd_pkg::ST_TOKEN;
            end else begin
              s.phase = sdrd_pkg::PH_DATA;
              s.bytes_left_in_sector = 10'(sdrd_pkg::SECTOR_BYTES);
            end
          end else if (s.poll_count >= c.token_poll_limit) begin
            fin = 1'b1;
            bad = 1'b1;
            st = sdrd_pkg::ST_TOKEN;
          end
        end
        sdrd_pkg::PH_DATA: begin
          if (s.offset_left != '0) begin
            s.offset_left = s.offset_left - 9'd1;
          end else if (s.length_left != '0) begin
            s.length_left = s.length_left - 32'd1;
            r.data_valid = 1'b1;
            r.data_byte = w.rx;
          end
          if (s.bytes_left_in_sector != '0)
            s.bytes_left_in_sector = s.bytes_left_in_sector - 10'd1;
          if (s.bytes_left_in_sector == '0) begin
            s.phase = sdrd_pkg::PH_CRC;
            s.frame_index = '0;
          end
        end
        sdrd_pkg::PH_CRC: begin
          if (s.frame_index == '0) begin
            s.frame_index = 3'd1;
          end else if (s.sectors_left != '0) begin
            s.sectors_left = s.sectors_left - 24'd1;
            s.card_address = s.card_address +
                             (c.block_addressing ? 32'd1 : 32'(sdrd_pkg::SECTOR_BYTES));
            frame_go = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          s.phase = sdrd_pkg::PH_IDLE;
          return 1'b0;
        end
      endcase
    end
    if (frame_go) begin
      s.phase = sdrd_pkg::PH_FRAME;
      s.frame_index = 3'd1;
      r.tx_valid = 1'b1;
      r.tx_byte = sdrd_pkg::CMD17_BYTE;
      r.select_restart = 1'b1;
    end
    if (fin) begin
      if (bad) s.link_good = 1'b0;
      s.phase = sdrd_pkg::PH_IDLE;
      r = '0;
      r.done_res = 1'b1;
      r.status = st;
    end
    return 1'b1;
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch on %s at result %0d: got %0h want %0h", what, results_seen, got, want);
  endtask

  function automatic word_t rand_word();
    word_t w;
    w.cmd = 1'($urandom_range(1));
    w.sector = $urandom();
    w.offset = 16'($urandom());
    w.length = $urandom();
    w.rx = 8'($urandom());
    return w;
  endfunction

  function automatic int poll_wait(input logic [15:0] lim);
    int top;
    top = (lim == '0) ? 0 : int'(lim) - 1;
    if (top > 40) top = 40;
    return $urandom_range(0, top);
  endfunction

  task automatic queue_word(input word_t w);
    sdrd_pkg::result_t r;
    pending.push_back(w);
    if (step_engine(plan, cfg_now, w, r)) made++;
  endtask

  task automatic start_word(input logic [31:0] sector, input logic [15:0] off,
                            input logic [31:0] length);
    word_t w;
    w = rand_word();
    w.cmd = sdrd_pkg::CMD_START;
    w.sector = sector;
    w.offset = off;
    w.length = length;
    queue_word(w);
  endtask

  task automatic stray_xfer();
    word_t w;
    w = rand_word();
    w.cmd = sdrd_pkg::CMD_XFER;
    queue_word(w);
  endtask

  // a start word followed by card replies until the request ends
  task automatic run_read(input logic [31:0] sector, input logic [15:0] off,
                          input logic [31:0] length, input fault_t fault);
    word_t  w;
    fault_t fault_now;
    int     r1_wait;
    int     tok_wait;
    r1_wait = 0;
    tok_wait = 0;
    start_word(sector, off, length);
    while (plan.phase != sdrd_pkg::PH_IDLE) begin
      w = rand_word();
      w.cmd = ($urandom_range(49) == 0) ? sdrd_pkg::CMD_START : sdrd_pkg::CMD_XFER;
      // a fault only hits the last sector of the read
      fault_now = (plan.sectors_left == '0) ? fault : FAULT_NONE;
      if (w.cmd == sdrd_pkg::CMD_XFER) begin
        case (plan.phase)
          sdrd_pkg::PH_RESP: begin
            if (plan.poll_count == '0)
              r1_wait = poll_wait(cfg_now.response_poll_limit);
            if (fault_now == FAULT_R1_SILENT || plan.poll_count < r1_wait) w.rx[7] = 1'b1;
            else if (fault_now == FAULT_R1) w.rx = 8'($urandom_range(1, 127));
            else w.rx = R1_READY;
          end
          sdrd_pkg::PH_TOKEN: begin
            if (plan.poll_count == '0)
              tok_wait = poll_wait(cfg_now.token_poll_limit);
            if (fault_now == FAULT_TOKEN_SILENT || plan.poll_count < tok_wait)
              w.rx = sdrd_pkg::IDLE_BYTE;
            else if (fault_now == FAULT_TOKEN) w.rx = 8'($urandom_range(0, 253));
            else w.rx = sdrd_pkg::DATA_TOKEN;
          end
          default: ;
        endcase
      end
      queue_word(w);
    end
  endtask

  task automatic random_read(input fault_t fault);
    logic [31:0] sector;
    logic [31:0] length;
    logic [15:0] off;
    int          pick;
    pick = $urandom_range(99);
    off = 16'($urandom_range(0, sdrd_pkg::SECTOR_BYTES - 1));
    if (pick < 70) length = $urandom_range(1, 48);
    else if (pick < 90) length = $urandom_range(1, 600);
    else length = $urandom_range(400, 1100);
    if (cfg_now.block_addressing)
      sector = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom();
    else
      sector = ($urandom_range(9) == 0) ? LAST_BYTE_SECTOR :
               $urandom_range(0, LAST_BYTE_SECTOR);
    run_read(sector, off, length, fault);
  endtask

  task automatic bad_args();
    logic [15:0] off;
    int          pick;
    pick = $urandom_range(cfg_now.block_addressing ? 1 : 2);
    off = 16'($urandom_range(1, sdrd_pkg::SECTOR_BYTES - 1));
    case (pick)
      0: start_word($urandom(), 16'($urandom_range(sdrd_pkg::SECTOR_BYTES, 65535)),
                    $urandom() | 32'd1);
      1: start_word($urandom(), off, 32'hFFFF_FFFF - off + $urandom_range(1, off));
      default: start_word($urandom_range(LAST_BYTE_SECTOR + 1, 32'hFFFF_FFFF), off,
                          $urandom_range(1, 4096));
    endcase
  endtask

  // short words only: rejected starts, empty reads and stray exchanges
  task automatic random_traffic(input int goal);
    int pick;
    made = 0;
    while (made < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) bad_args();
      else if (pick < 80) start_word($urandom(), 16'($urandom()), 32'd0);
      else stray_xfer();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sdrd_pkg::REG_BLOCK_ADDR:  cfg_now.block_addressing = data[0];
      sdrd_pkg::REG_RESP_LIMIT:  cfg_now.response_poll_limit = data[15:0];
      sdrd_pkg::REG_TOKEN_LIMIT: cfg_now.token_poll_limit = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (pending.size() != 0 || in_valid || replies.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // input side: predict at accept
  always @(posedge clk) begin : accept_side
    word_t             w;
    sdrd_pkg::result_t r;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        w = {cmd, start_sector, start_offset, read_length, rx_byte};
        if (step_engine(eng, cfg_now, w, r)) replies.push_back(r);
        words_in++;
      end
    end
  end

  always @(negedge clk) begin : feed
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_gap) begin
        w = pending.pop_front();
        in_valid <= 1'b1;
        cmd <= w.cmd;
        start_sector <= w.sector;
        start_offset <= w.offset;
        read_length <= w.length;
        rx_byte <= w.rx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !choke && ($urandom_range(99) >= recv_gap);
  end

  // long receiver hold-off so the engine backs up into its input
  initial begin
    choke = 1'b0;
    wait (choke_req);
    @(negedge clk);
    choke <= 1'b1;
    repeat (300) @(negedge clk);
    choke <= 1'b0;
  end

  always @(posedge clk) begin : check_side
    sdrd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (replies.size() == 0) begin
        flag("unexpected result", 32'(tx_byte), 32'd0);
      end else begin
        want = replies.pop_front();
        if (tx_valid !== want.tx_valid) flag("tx_valid", 32'(tx_valid), 32'(want.tx_valid));
        if (tx_byte !== want.tx_byte) flag("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
        if (select_restart !== want.select_restart)
          flag("select_restart", 32'(select_restart), 32'(want.select_restart));
        if (data_valid !== want.data_valid)
          flag("data_valid", 32'(data_valid), 32'(want.data_valid));
        if (data_byte !== want.data_byte) flag("data_byte", 32'(data_byte), 32'(want.data_byte));
        if (done_res !== want.done_res) flag("done_res", 32'(done_res), 32'(want.done_res));
        if (status !== want.status) flag("status", 32'(status), 32'(want.status));
      end
      if (select_restart === 1'b1) frames_seen++;
      if (data_valid === 1'b1) bytes_seen++;
      if (done_res === 1'b1 && status <= sdrd_pkg::ST_LINK) ends[status]++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run
    plan = '0;
    plan.link_good = 1'b1;
    eng = plan;
    cfg_now.block_addressing = 1'b0;
    cfg_now.response_poll_limit = sdrd_pkg::POLL_LIMIT_RESET;
    cfg_now.token_poll_limit = sdrd_pkg::POLL_LIMIT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // byte addressing, start checks at the edges
    send_gap = 8;
    recv_gap = 49;
    write_reg(sdrd_pkg::REG_BLOCK_ADDR, $urandom() & 32'hFFFF_FFFE);
    write_reg(sdrd_pkg::REG_RESP_LIMIT, {16'($urandom()), 16'd1});
    write_reg(sdrd_pkg::REG_TOKEN_LIMIT, {16'($urandom()), 16'hFFFF});
    stray_xfer();
    start_word(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    start_word(32'd0, 16'(sdrd_pkg::SECTOR_BYTES), 32'd1);
    start_word(32'd0, 16'hFFFF, 32'hFFFF_FFFF);
    start_word(32'd0, 16'd1, 32'hFFFF_FFFF);
    start_word(LAST_BYTE_SECTOR + 1, 16'd0, 32'hFFFF_FFFF);
    start_word(32'hFFFF_FFFF, 16'd0, 32'd1);
    random_traffic(30);
    settle();

    // sector addressing, limits swapped
    send_gap = 49;
    recv_gap = 8;
    write_reg(sdrd_pkg::REG_BLOCK_ADDR, $urandom() | 32'd1);
    write_reg(sdrd_pkg::REG_RESP_LIMIT, {16'($urandom()), 16'hFFFF});
    write_reg(sdrd_pkg::REG_TOKEN_LIMIT, {16'($urandom()), 16'd1});
    random_traffic(30);
    settle();

    // no idling, zero response limit, long output stall
    send_gap = 0;
    recv_gap = 0;
    write_reg(sdrd_pkg::REG_BLOCK_ADDR, $urandom());
    write_reg(sdrd_pkg::REG_RESP_LIMIT, {16'($urandom()), 16'd0});
    write_reg(sdrd_pkg::REG_TOKEN_LIMIT, {16'($urandom()), 16'($urandom_range(2, 40))});
    random_traffic(40);
    choke_req = 1'b1;
    settle();

    // small limits, a two-sector read across the address wrap that fails
    // on its second sector, then a dead link
    write_reg(sdrd_pkg::REG_BLOCK_ADDR, $urandom());
    write_reg(sdrd_pkg::REG_RESP_LIMIT, {16'($urandom()), 16'($urandom_range(1, 12))});
    write_reg(sdrd_pkg::REG_TOKEN_LIMIT, {16'($urandom()), 16'($urandom_range(0, 12))});
    write_reg(REG_UNUSED, $urandom());
    random_traffic(10);
    run_read(cfg_now.block_addressing ? 32'hFFFF_FFFF : LAST_BYTE_SECTOR,
             16'(sdrd_pkg::SECTOR_BYTES - 1), 32'd2,
             fault_t'($urandom_range(FAULT_R1, FAULT_TOKEN_SILENT)));
    repeat (4) begin
      bad_args();
      start_word($urandom(), 16'($urandom()), 32'd0);
      random_read(FAULT_NONE);
      stray_xfer();
    end
    settle();

    $display("covered %0d words in, %0d results, %0d command frames, %0d payload bytes",
             words_in, results_seen, frames_seen, bytes_seen);
    $display("request ends ok/arg/reject/token/link: %0d/%0d/%0d/%0d/%0d",
             ends[sdrd_pkg::ST_OK], ends[sdrd_pkg::ST_ARG], ends[sdrd_pkg::ST_REJECT],
             ends[sdrd_pkg::ST_TOKEN], ends[sdrd_pkg::ST_LINK]);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
